/* rtl/plw_pkg.sv */
// Shared constants, types and the CORDIC angle table of the landmark weight core.
`default_nettype none
package plw_pkg;
	localparam int MAX_LANDMARKS_DEF    = 64;
	localparam int MAX_OBSERVATIONS_DEF = 16;
	localparam int CORDIC_STEPS_DEF     = 16;
	localparam int ANGLE_TABLE_LEN      = 24;

	localparam int IN_DATA_W  = 168;
	localparam int OUT_DATA_W = 32;
	localparam int CFG_DATA_W = 48;
	localparam int CFG_IDX_W  = 3;

	localparam int XW = 44;
	localparam int ZW = 33;
	localparam int PW = 67;
	localparam int MW = 28;
	localparam int DW = 29;
	localparam int SW = 58;

	localparam logic signed [30:0] INV_GAIN_Q30 = 31'sd652032874;
	localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;

	localparam logic [1:0] ACT_LOAD_LANDMARK = 2'd0;
	localparam logic [1:0] ACT_LOAD_OBS      = 2'd1;
	localparam logic [1:0] ACT_EVALUATE      = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_LANDMARK_COUNT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OBS_COUNT      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RANGE_SQUARED  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_INV_VAR_X      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_INV_VAR_Y      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_LOG_NORM       = 3'd5;

	localparam logic [ZW-1:0] ANGLE_STEP [ANGLE_TABLE_LEN] = '{
		33'h020000000, 33'h012E4051E, 33'h009FB385B, 33'h0051111D4, 33'h0028B0D43,
		33'h00145D7E1, 33'h000A2F61E, 33'h000517C55, 33'h00028BE53, 33'h000145F2F,
		33'h0000A2F98, 33'h0000517CC, 33'h000028BE6, 33'h0000145F3, 33'h00000A2FA,
		33'h00000517D, 33'h0000028BE, 33'h00000145F, 33'h000000A30, 33'h000000518,
		33'h00000028C, 33'h000000146, 33'h0000000A3, 33'h000000051
	};

	typedef enum logic [4:0] {
		ST_IDLE, ST_C_ADDR, ST_C_SQ, ST_C_CMP, ST_O_ADDR, ST_O_LOAD, ST_O_WAIT,
		ST_O_UNSC, ST_O_MAP, ST_L_ADDR, ST_L_DIFF, ST_L_SQ, ST_L_CMP, ST_E_MLO,
		ST_E_MHI, ST_E_ADD, ST_E_LN, ST_RESULT
	} state_t;
endpackage
`default_nettype wire

/* rtl/particle_landmark_weight_core.sv */
// Top level of the particle landmark weight core: stores, sequencer and rotation chain.
//
// Channel  Direction  Contents
// s_*      in         tuser action; tdata slot, landmark, observation, particle pose
// m_*      out        tuser no-landmark flag; tdata neg_log_weight
// cfg_*    in         register writes, index and data
//
// A load is written as it is accepted. An evaluation first scans every landmark for range,
// then for each observation runs the rotation chain and one sweep of the single landmark
// store read port. Reset clears control state and the configuration registers; the
// stores hold nothing until loaded. A waiting result holds the next evaluation at its
// final transfer, and no input is taken while it waits.
`default_nettype none
module particle_landmark_weight_core #(
	parameter int MAX_LANDMARKS    = plw_pkg::MAX_LANDMARKS_DEF,
	parameter int MAX_OBSERVATIONS = plw_pkg::MAX_OBSERVATIONS_DEF,
	parameter int CORDIC_STEPS     = plw_pkg::CORDIC_STEPS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// slot, landmark_x, landmark_y, obs_x, obs_y, particle_x, particle_y, particle_heading
	input  logic [plw_pkg::IN_DATA_W-1:0]     s_tdata,
	// action
	input  logic [1:0]                        s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// neg_log_weight
	output logic [plw_pkg::OUT_DATA_W-1:0]    m_tdata,
	// no_landmark_in_range
	output logic [0:0]                        m_tuser,
	input  logic                              cfg_we,
	input  logic [plw_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [plw_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
	import plw_pkg::*;

	localparam int LA = (MAX_LANDMARKS > 1) ? $clog2(MAX_LANDMARKS) : 1;
	localparam int LC = $clog2(MAX_LANDMARKS + 1);
	localparam int OA = (MAX_OBSERVATIONS > 1) ? $clog2(MAX_OBSERVATIONS) : 1;
	localparam int OC = $clog2(MAX_OBSERVATIONS + 1);
	localparam int CW = $clog2(CORDIC_STEPS + 1);
	localparam logic signed [PW-1:0] ROUND_HALF = PW'(1) <<< 37;

	state_t state_q, state_d;

	logic [6:0]  lm_count_q;
	logic [4:0]  obs_count_q;
	logic [47:0] range_q;
	logic [23:0] ivx_q, ivy_q;
	logic [15:0] lnorm_q;

	logic [47:0] lm_mem  [MAX_LANDMARKS];
	logic [47:0] obs_mem [MAX_OBSERVATIONS];
	logic [47:0] lm_rd_q, obs_rd_q;

	logic [LC-1:0] kq, nl;
	logic [OC-1:0] jq, no;
	logic [CW-1:0] wait_q;
	logic [MAX_LANDMARKS-1:0] cand_q;
	logic any_q, found_q, axis_q, cand_k_q, flag_q;

	logic signed [23:0] px_q, py_q;
	logic [15:0] hd_q;
	logic [49:0] csqx_q, csqy_q;
	logic signed [PW-1:0] prodx_q, prody_q;
	logic signed [MW-1:0] mx_q, my_q;
	logic signed [DW-1:0] dx_q, dy_q;
	logic [SW-1:0] sqx_q, sqy_q, bsqx_q, bsqy_q;
	logic [SW:0] best_q;
	logic [52:0] pl_q, ph_q;
	logic [31:0] acc_q;

	logic signed [XW-1:0] cx [CORDIC_STEPS+1];
	logic signed [XW-1:0] cy [CORDIC_STEPS+1];
	logic signed [ZW-1:0] cz [CORDIC_STEPS+1];
	logic signed [XW-1:0] cx0_q, cy0_q;
	logic signed [ZW-1:0] cz0_q;

	logic accept, out_free, k_last, j_last;
	assign accept   = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign out_free = !m_tvalid || m_tready;

	always_comb begin
		nl = (int'(lm_count_q) > MAX_LANDMARKS) ? LC'(MAX_LANDMARKS) : LC'(lm_count_q);
		no = (int'(obs_count_q) > MAX_OBSERVATIONS) ? OC'(MAX_OBSERVATIONS)
			: OC'(obs_count_q);
	end
	assign k_last = (kq == nl - LC'(1));
	assign j_last = (jq == no - OC'(1));

	// Input fields.
	logic [5:0] in_slot;
	logic [23:0] in_lx, in_ly, in_ox, in_oy, in_px, in_py;
	logic [15:0] in_hd;
	assign in_slot = s_tdata[5:0];
	assign in_lx   = s_tdata[29:6];
	assign in_ly   = s_tdata[53:30];
	assign in_ox   = s_tdata[77:54];
	assign in_oy   = s_tdata[101:78];
	assign in_px   = s_tdata[125:102];
	assign in_py   = s_tdata[149:126];
	assign in_hd   = s_tdata[165:150];

	// Stores.
	always_ff @(posedge clk) begin
		if (accept && s_tuser == ACT_LOAD_LANDMARK && int'(in_slot) < MAX_LANDMARKS)
			lm_mem[LA'(in_slot)] <= {in_lx, in_ly};
		if (accept && s_tuser == ACT_LOAD_OBS && int'(in_slot) < MAX_OBSERVATIONS)
			obs_mem[OA'(in_slot)] <= {in_ox, in_oy};
		lm_rd_q  <= lm_mem[kq[LA-1:0]];
		obs_rd_q <= obs_mem[jq[OA-1:0]];
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lm_count_q  <= '0;
			obs_count_q <= '0;
			range_q     <= '0;
			ivx_q       <= 24'd65536;
			ivy_q       <= 24'd65536;
			lnorm_q     <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LANDMARK_COUNT: lm_count_q  <= cfg_wdata[6:0];
				REG_OBS_COUNT:      obs_count_q <= cfg_wdata[4:0];
				REG_RANGE_SQUARED:  range_q     <= cfg_wdata[47:0];
				REG_INV_VAR_X:      ivx_q       <= cfg_wdata[23:0];
				REG_INV_VAR_Y:      ivy_q       <= cfg_wdata[23:0];
				REG_LOG_NORM:       lnorm_q     <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	// Rotation chain.
	assign cx[0] = cx0_q;
	assign cy[0] = cy0_q;
	assign cz[0] = cz0_q;
	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
		plw_cordic_cell #(.IDX(i)) u_cell (
			.clk  (clk),
			.x_in (cx[i]),
			.y_in (cy[i]),
			.z_in (cz[i]),
			.x_out(cx[i+1]),
			.z_out(cz[i+1]),
			.y_out(cy[i+1])
		);
	end

	// Combinational helpers.
	logic signed [24:0] cdx, cdy;
	logic [24:0] cax, cay;
	logic [50:0] csum;
	logic [1:0]  quad;
	logic signed [15:0] resid;
	logic signed [23:0] ox, oy;
	logic signed [24:0] vx, vy;
	logic signed [35:0] ushx, ushy;
	logic signed [PW-1:0] rxf, ryf;
	logic signed [DW-1:0] ldx, ldy;
	logic [DW-1:0] lax, lay;
	logic [SW:0] lsum;
	logic [SW-1:0] esel;
	logic [23:0] eiv;
	logic [81:0] efull;
	logic [39:0] eterm;
	logic [40:0] esum, nsum;

	always_comb begin
		cdx  = 25'(signed'(lm_rd_q[47:24])) - 25'(px_q);
		cdy  = 25'(signed'(lm_rd_q[23:0])) - 25'(py_q);
		cax  = cdx[24] ? 25'(-cdx) : 25'(cdx);
		cay  = cdy[24] ? 25'(-cdy) : 25'(cdy);
		csum = {1'b0, csqx_q} + {1'b0, csqy_q};

		quad  = hd_q[15:14] + {1'b0, hd_q[13]};
		resid = signed'(hd_q - {quad, 14'd0});
		ox    = signed'(obs_rd_q[47:24]);
		oy    = signed'(obs_rd_q[23:0]);
		case (quad)
			2'd1:    begin vx = -25'(oy); vy = 25'(ox);  end
			2'd2:    begin vx = -25'(ox); vy = -25'(oy); end
			2'd3:    begin vx = 25'(oy);  vy = -25'(ox); end
			default: begin vx = 25'(ox);  vy = 25'(oy);  end
		endcase

		ushx = 36'(cx[CORDIC_STEPS] >>> 8);
		ushy = 36'(cy[CORDIC_STEPS] >>> 8);
		rxf  = (prodx_q + ROUND_HALF) >>> 38;
		ryf  = (prody_q + ROUND_HALF) >>> 38;

		ldx  = DW'(signed'(lm_rd_q[47:24])) - DW'(mx_q);
		ldy  = DW'(signed'(lm_rd_q[23:0])) - DW'(my_q);
		lax  = dx_q[DW-1] ? DW'(-dx_q) : DW'(dx_q);
		lay  = dy_q[DW-1] ? DW'(-dy_q) : DW'(dy_q);
		lsum = {1'b0, sqx_q} + {1'b0, sqy_q};

		esel  = axis_q ? bsqy_q : bsqx_q;
		eiv   = axis_q ? ivy_q : ivx_q;
		efull = (82'(ph_q) << 29) + 82'(pl_q);
		eterm = (efull[81:64] != '0) ? 40'(SAT32) : 40'(efull[63:25]);
		esum  = 41'(acc_q) + 41'(eterm);
		nsum  = 41'(acc_q) + 41'(lnorm_q);
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:
				if (accept && s_tuser == ACT_EVALUATE)
					state_d = (nl == '0) ? ST_RESULT : ST_C_ADDR;
			ST_C_ADDR: state_d = ST_C_SQ;
			ST_C_SQ:   state_d = ST_C_CMP;
			ST_C_CMP: begin
				if (!k_last)
					state_d = ST_C_ADDR;
				else if (!(any_q || csum < 51'(range_q)) || no == '0)
					state_d = ST_RESULT;
				else
					state_d = ST_O_ADDR;
			end
			ST_O_ADDR: state_d = ST_O_LOAD;
			ST_O_LOAD: state_d = ST_O_WAIT;
			ST_O_WAIT: if (wait_q == CW'(CORDIC_STEPS - 1)) state_d = ST_O_UNSC;
			ST_O_UNSC: state_d = ST_O_MAP;
			ST_O_MAP:  state_d = ST_L_ADDR;
			ST_L_ADDR: state_d = ST_L_DIFF;
			ST_L_DIFF: state_d = ST_L_SQ;
			ST_L_SQ:   state_d = ST_L_CMP;
			ST_L_CMP:  state_d = k_last ? ST_E_MLO : ST_L_ADDR;
			ST_E_MLO:  state_d = ST_E_MHI;
			ST_E_MHI:  state_d = ST_E_ADD;
			ST_E_ADD:  state_d = axis_q ? ST_E_LN : ST_E_MLO;
			ST_E_LN:   state_d = j_last ? ST_RESULT : ST_O_ADDR;
			ST_RESULT: if (out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kq       <= '0;
			jq       <= '0;
			wait_q   <= '0;
			cand_q   <= '0;
			any_q    <= 1'b0;
			found_q  <= 1'b0;
			axis_q   <= 1'b0;
			cand_k_q <= 1'b0;
			flag_q   <= 1'b0;
			best_q   <= '0;
			bsqx_q   <= '0;
			bsqy_q   <= '0;
			acc_q    <= '0;
			m_tvalid <= 1'b0;
			m_tdata  <= '0;
			m_tuser  <= '0;
		end else begin
			if (state_q == ST_RESULT && out_free) begin
				m_tvalid <= 1'b1;
				m_tdata  <= acc_q;
				m_tuser  <= flag_q;
			end else if (m_tvalid && m_tready) begin
				m_tvalid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					kq     <= '0;
					jq     <= '0;
					any_q  <= 1'b0;
					acc_q  <= SAT32;
					flag_q <= 1'b1;
				end
				ST_C_CMP: begin
					cand_q[kq[LA-1:0]] <= csum < 51'(range_q);
					any_q <= any_q || csum < 51'(range_q);
					if (k_last) begin
						kq <= '0;
						if (any_q || csum < 51'(range_q)) begin
							acc_q  <= '0;
							flag_q <= 1'b0;
						end
					end else begin
						kq <= kq + LC'(1);
					end
				end
				ST_O_LOAD: wait_q <= '0;
				ST_O_WAIT: wait_q <= wait_q + CW'(1);
				ST_O_MAP: begin
					kq      <= '0;
					found_q <= 1'b0;
				end
				ST_L_DIFF: cand_k_q <= cand_q[kq[LA-1:0]];
				ST_L_CMP: begin
					if (cand_k_q && (!found_q || lsum < best_q)) begin
						found_q <= 1'b1;
						best_q  <= lsum;
						bsqx_q  <= sqx_q;
						bsqy_q  <= sqy_q;
					end
					kq     <= k_last ? '0 : kq + LC'(1);
					axis_q <= 1'b0;
				end
				ST_E_ADD: begin
					acc_q  <= (esum > 41'(SAT32)) ? SAT32 : esum[31:0];
					axis_q <= 1'b1;
				end
				ST_E_LN: begin
					acc_q <= (nsum > 41'(SAT32)) ? SAT32 : nsum[31:0];
					jq    <= jq + OC'(1);
				end
				default: ;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			px_q <= signed'(in_px);
			py_q <= signed'(in_py);
			hd_q <= in_hd;
		end
		csqx_q  <= cax * cax;
		csqy_q  <= cay * cay;
		if (state_q == ST_O_LOAD) begin
			cx0_q <= XW'(vx) <<< 16;
			cy0_q <= XW'(vy) <<< 16;
			cz0_q <= ZW'(resid) <<< 16;
		end
		prodx_q <= ushx * INV_GAIN_Q30;
		prody_q <= ushy * INV_GAIN_Q30;
		if (state_q == ST_O_MAP) begin
			mx_q <= MW'(px_q) + MW'(rxf);
			my_q <= MW'(py_q) + MW'(ryf);
		end
		dx_q  <= ldx;
		dy_q  <= ldy;
		sqx_q <= lax * lax;
		sqy_q <= lay * lay;
		pl_q  <= esel[28:0] * eiv;
		ph_q  <= esel[57:29] * eiv;
	end
endmodule
`default_nettype wire

/* rtl/plw_cordic_cell.sv */
// One rotation-mode CORDIC step; a row of these forms the rotation chain.
`default_nettype none
module plw_cordic_cell #(
	parameter int IDX = 0
) (
	input  logic                          clk,
	input  logic signed [plw_pkg::XW-1:0] x_in,
	input  logic signed [plw_pkg::XW-1:0] y_in,
	input  logic signed [plw_pkg::ZW-1:0] z_in,
	output logic signed [plw_pkg::XW-1:0] x_out,
	output logic signed [plw_pkg::ZW-1:0] z_out,
	output logic signed [plw_pkg::XW-1:0] y_out
);
	import plw_pkg::*;

	localparam logic signed [ZW-1:0] ANGLE = ANGLE_STEP[IDX];

	logic signed [XW-1:0] x_q, y_q;
	logic signed [ZW-1:0] z_q;

	always_ff @(posedge clk) begin
		if (z_in >= 0) begin
			x_q <= x_in - (y_in >>> IDX);
			y_q <= y_in + (x_in >>> IDX);
			z_q <= z_in - ANGLE;
		end else begin
			x_q <= x_in + (y_in >>> IDX);
			y_q <= y_in - (x_in >>> IDX);
			z_q <= z_in + ANGLE;
		end
	end

	assign x_out = x_q;
	assign y_out = y_q;
	assign z_out = z_q;
endmodule
`default_nettype wire

/* tb/plw_checker.sv */
// Checker for the landmark weight core: follows the channels, predicts each weight and compares.
`default_nettype none
module plw_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	input  logic                              s_tready,
	input  logic [plw_pkg::IN_DATA_W-1:0]     s_tdata,
	input  logic [1:0]                        s_tuser,
	input  logic                              m_tvalid,
	input  logic                              m_tready,
	input  logic [plw_pkg::OUT_DATA_W-1:0]    m_tdata,
	input  logic [0:0]                        m_tuser,
	input  logic                              cfg_we,
	input  logic [plw_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [plw_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	output int                                errors,
	output int                                pending,
	output int                                results_seen
);
	import plw_pkg::*;

	typedef struct packed {
		logic [31:0] weight;
		logic        no_lm;
	} weight_t;

	weight_t weight_q [$];

	logic signed [23:0] lm_x [MAX_LANDMARKS_DEF];
	logic signed [23:0] lm_y [MAX_LANDMARKS_DEF];
	logic signed [23:0] ob_x [MAX_OBSERVATIONS_DEF];
	logic signed [23:0] ob_y [MAX_OBSERVATIONS_DEF];

	logic [6:0]  lm_count;
	logic [4:0]  ob_count;
	logic [47:0] range_sq;
	logic [23:0] ivx;
	logic [23:0] ivy;
	logic [15:0] ln_norm;

	function automatic longint unsigned sq(input longint d);
		longint a;
		a = d < 0 ? -d : d;
		return longint'(a) * longint'(a);
	endfunction

	function automatic longint unsigned err_term(input longint unsigned d2,
			input longint unsigned iv);
		if (iv != 0 && d2 > 64'hFFFF_FFFF_FFFF_FFFF / iv)
			return 64'hFFFF_FFFF;
		return (d2 * iv) >> 25;
	endfunction

	function automatic longint unsigned acc_add(input longint unsigned a,
			input longint unsigned b);
		longint unsigned s;
		s = a + b;
		return s > 64'hFFFF_FFFF ? 64'hFFFF_FFFF : s;
	endfunction

	function automatic longint remove_gain(input longint v);
		longint p;
		p = (v >>> 8) * longint'(INV_GAIN_Q30);
		return (p + (longint'(1) <<< 37)) >>> 38;
	endfunction

	function automatic void rotate_obs(input longint ox, input longint oy,
			input logic [15:0] hd, output longint rx, output longint ry);
		logic [1:0] q;
		logic [15:0] res;
		longint x, y, z, nx, ny, vx, vy;
		q = 2'((32'(hd) + 32'h2000) >> 14);
		res = hd - 16'(q) * 16'd16384;
		case (q)
			2'd0: begin vx = ox; vy = oy; end
			2'd1: begin vx = -oy; vy = ox; end
			2'd2: begin vx = -ox; vy = -oy; end
			default: begin vx = oy; vy = -ox; end
		endcase
		x = vx * 65536;
		y = vy * 65536;
		z = longint'($signed(res)) * 65536;
		for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i); ny = y + (x >>> i); z -= longint'(ANGLE_STEP[i]);
			end else begin
				nx = x + (y >>> i); ny = y - (x >>> i); z += longint'(ANGLE_STEP[i]);
			end
			x = nx;
			y = ny;
		end
		rx = remove_gain(x);
		ry = remove_gain(y);
	endfunction

	function automatic weight_t particle_weight(input logic signed [23:0] px_i,
			input logic signed [23:0] py_i, input logic [15:0] hd);
		weight_t r;
		bit cand [MAX_LANDMARKS_DEF];
		bit any, found;
		int nl, no;
		longint px, py, rx, ry, mx, my, bx, by;
		longint unsigned acc, best, d2;
		px = px_i;
		py = py_i;
		nl = lm_count > MAX_LANDMARKS_DEF ? MAX_LANDMARKS_DEF : lm_count;
		no = ob_count > MAX_OBSERVATIONS_DEF ? MAX_OBSERVATIONS_DEF : ob_count;
		any = 0;
		acc = 0;
		for (int k = 0; k < nl; k++) begin
			cand[k] = sq(longint'(lm_x[k]) - px) + sq(longint'(lm_y[k]) - py) < range_sq;
			if (cand[k])
				any = 1;
		end
		if (!any) begin
			r.weight = SAT32;
			r.no_lm = 1'b1;
			return r;
		end
		for (int j = 0; j < no; j++) begin
			rotate_obs(ob_x[j], ob_y[j], hd, rx, ry);
			mx = px + rx;
			my = py + ry;
			found = 0;
			best = 0;
			bx = 0;
			by = 0;
			for (int k = 0; k < nl; k++) begin
				if (cand[k]) begin
					d2 = sq(longint'(lm_x[k]) - mx) + sq(longint'(lm_y[k]) - my);
					if (!found || d2 < best) begin
						found = 1; best = d2; bx = lm_x[k]; by = lm_y[k];
					end
				end
			end
			acc = acc_add(acc, err_term(sq(bx - mx), ivx));
			acc = acc_add(acc, err_term(sq(by - my), ivy));
			acc = acc_add(acc, ln_norm);
		end
		r.weight = acc[31:0];
		r.no_lm = 1'b0;
		return r;
	endfunction

	task automatic report(input string what, input longint unsigned want,
			input longint unsigned got);
		$display("mismatch on %s: expected %0h, got %0h", what, want, got);
		errors++;
	endtask

	initial begin
		errors = 0;
		results_seen = 0;
	end

	assign pending = weight_q.size();

	always @(posedge clk or negedge arst_n) begin
		weight_t w;
		logic [5:0] slot;
		if (!arst_n) begin
			lm_count <= 7'd0;
			ob_count <= 5'd0;
			range_sq <= 48'd0;
			ivx <= 24'd65536;
			ivy <= 24'd65536;
			ln_norm <= 16'd0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_LANDMARK_COUNT: lm_count <= cfg_wdata[6:0];
					REG_OBS_COUNT: ob_count <= cfg_wdata[4:0];
					REG_RANGE_SQUARED: range_sq <= cfg_wdata;
					REG_INV_VAR_X: ivx <= cfg_wdata[23:0];
					REG_INV_VAR_Y: ivy <= cfg_wdata[23:0];
					REG_LOG_NORM: ln_norm <= cfg_wdata[15:0];
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (weight_q.size() == 0) begin
					report("unexpected result", 0, m_tdata);
				end else begin
					w = weight_q.pop_front();
					if (m_tdata !== w.weight)
						report("neg_log_weight", w.weight, m_tdata);
					if (m_tuser[0] !== w.no_lm)
						report("no_landmark_in_range", w.no_lm, m_tuser[0]);
				end
			end
			if (s_tvalid && s_tready) begin
				slot = s_tdata[5:0];
				case (s_tuser)
					ACT_LOAD_LANDMARK: begin
						lm_x[slot] = s_tdata[29:6];
						lm_y[slot] = s_tdata[53:30];
					end
					ACT_LOAD_OBS: begin
						if (slot < MAX_OBSERVATIONS_DEF) begin
							ob_x[slot[3:0]] = s_tdata[77:54];
							ob_y[slot[3:0]] = s_tdata[101:78];
						end
					end
					ACT_EVALUATE: begin
						weight_q.insert(weight_q.size(), particle_weight(s_tdata[125:102],
							s_tdata[149:126], s_tdata[165:150]));
					end
					default: ;
				endcase
			end
		end
	end
endmodule
`default_nettype wire

/* tb/tb.sv */
// Testbench top of the landmark weight core: stimulus, receiver stalls and the verdict.
`default_nettype none
module tb;
	import plw_pkg::*;

	localparam int LIMIT = 20000000;
	localparam logic [1:0] ACT_RESERVED = 2'd3;

	logic                    clk;
	logic                    arst_n;
	logic                    s_tvalid;
	logic                    s_tready;
	logic [IN_DATA_W-1:0]    s_tdata;
	logic [1:0]              s_tuser;
	logic                    m_tvalid;
	logic                    m_tready;
	logic [OUT_DATA_W-1:0]   m_tdata;
	logic [0:0]              m_tuser;
	logic                    cfg_we;
	logic [CFG_IDX_W-1:0]    cfg_index;
	logic [CFG_DATA_W-1:0]   cfg_wdata;

	int errors;
	int pending;
	int results_seen;
	int cycles;
	int burst_left;
	int transfers;
	int settings;

	particle_landmark_weight_core uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	plw_checker chk (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.errors(errors), .pending(pending), .results_seen(results_seen)
	);

	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial cycles = 0;
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// The receiver cycles through steady, random, long-stall and mostly-ready stretches.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			case ((cycles / 300) % 4)
				0: m_tready <= 1'b1;
				1: m_tready <= 1'($urandom_range(0, 1));
				2: m_tready <= (cycles % 37) > 29;
				default: m_tready <= $urandom_range(0, 9) != 0;
			endcase
		end
	end

	function automatic logic [23:0] coord();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 24'($urandom_range(0, 8191)) - 24'd4096;
		if (r < 90)
			return 24'($urandom);
		return r[0] ? 24'h7F_FFFF : 24'h80_0000;
	endfunction

	function automatic logic [15:0] heading();
		logic [15:0] picks [8] = '{16'h0000, 16'h1FFF, 16'h2000, 16'h4000,
			16'h8000, 16'hC000, 16'hDFFF, 16'hFFFF};
		if ($urandom_range(0, 4) == 0)
			return picks[$urandom_range(0, 7)];
		return 16'($urandom);
	endfunction

	function automatic logic [IN_DATA_W-1:0] pack(input logic [5:0] slot,
			input logic [23:0] lx, input logic [23:0] ly, input logic [23:0] ox,
			input logic [23:0] oy, input logic [23:0] px, input logic [23:0] py,
			input logic [15:0] hd);
		return {2'b00, hd, py, px, oy, ox, ly, lx, slot};
	endfunction

	task automatic send(input logic [1:0] act, input logic [IN_DATA_W-1:0] d);
		if (burst_left == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = $urandom_range(0, 3) == 0 ? 60 : $urandom_range(1, 12);
		end
		s_tvalid <= 1'b1;
		s_tuser <= act;
		s_tdata <= d;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		burst_left--;
		transfers++;
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_regs(input logic [47:0] nl, input logic [47:0] no,
			input logic [47:0] rs, input logic [47:0] vx, input logic [47:0] vy,
			input logic [47:0] ln);
		logic [47:0] vals [6];
		vals = '{nl, no, rs, vx, vy, ln};
		for (int i = 0; i < 6; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= CFG_IDX_W'(i);
			cfg_wdata <= vals[i];
			@(posedge clk);
		end
		// An index past the register list must leave everything alone.
		cfg_we <= 1'b1;
		cfg_index <= CFG_IDX_W'($urandom_range(6, 7));
		cfg_wdata <= 48'({$urandom, $urandom});
		@(posedge clk);
		cfg_we <= 1'b0;
		settings++;
	endtask

	task automatic evaluate(input logic [23:0] px, input logic [23:0] py,
			input logic [15:0] hd);
		send(ACT_EVALUATE, pack(6'($urandom), coord(), coord(), coord(), coord(), px, py, hd));
	endtask

	task automatic random_item();
		int r;
		logic [5:0] slot;
		r = $urandom_range(0, 99);
		slot = 6'($urandom);
		if (r < 60)
			evaluate(coord(), coord(), heading());
		else if (r < 78)
			send(ACT_LOAD_LANDMARK, pack(slot, coord(), coord(), coord(), coord(),
				coord(), coord(), heading()));
		else if (r < 95)
			send(ACT_LOAD_OBS, pack(slot, coord(), coord(), coord(), coord(),
				coord(), coord(), heading()));
		else
			send(ACT_RESERVED, pack(slot, coord(), coord(), coord(), coord(),
				coord(), coord(), heading()));
	endtask

	function automatic logic [47:0] pick_count(input int depth, input int wmax);
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return 0;
		if (r == 1)
			return depth;
		if (r == 2)
			return $urandom_range(depth + 1, wmax);
		return $urandom_range(1, depth / 8 > 4 ? 8 : 4);
	endfunction

	function automatic logic [47:0] pick_wide(input int w, input logic [47:0] typ);
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return 0;
		if (r == 1)
			return (48'd1 << w) - 1;
		if (r < 4)
			return 48'({$urandom, $urandom} & ((48'd1 << w) - 1));
		return 48'({$urandom, $urandom} % (typ + 1));
	endfunction

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		burst_left = 0;
		transfers = 0;
		settings = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Fill both stores so that no count can reach a slot that was never written.
		for (int i = 0; i < 64; i++)
			send(ACT_LOAD_LANDMARK, pack(6'(i), coord(), coord(), coord(), coord(),
				coord(), coord(), heading()));
		for (int i = 0; i < 16; i++)
			send(ACT_LOAD_OBS, pack(6'(i), coord(), coord(), coord(), coord(),
				coord(), coord(), heading()));

		// Reset register values: range zero leaves no candidate.
		evaluate(24'd0, 24'd0, 16'd0);
		drain();
		set_regs(64, 16, 48'hFFFF_FFFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 16'hFFFF);
		evaluate(24'h7F_FFFF, 24'h80_0000, 16'h2000);
		evaluate(24'h80_0000, 24'h7F_FFFF, 16'h1FFF);
		evaluate(24'd0, 24'd0, 16'hFFFF);
		drain();
		set_regs(127, 0, 48'hFFFF_FFFF_FFFF, 0, 0, 0);
		evaluate(24'd0, 24'd0, 16'h4000);
		drain();
		set_regs(4, 31, 48'h0800_0000, 24'h01_0000, 24'h00_4000, 16'h0180);
		send(ACT_LOAD_OBS, pack(6'd40, 24'd0, 24'd0, 24'd5, 24'd6, 24'd0, 24'd0, 16'd0));
		send(ACT_RESERVED, pack(6'd63, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF,
			24'hFF_FFFF, 24'hFF_FFFF, 16'hFFFF));
		evaluate(24'd0, 24'd0, 16'h8000);
		evaluate(24'd100, 24'hFF_FF00, 16'hC000);
		evaluate(24'd0, 24'd0, 16'hDFFF);
		drain();

		while (transfers < 570) begin
			set_regs(pick_count(64, 127), pick_count(16, 31), pick_wide(48, 48'h1000_0000),
				pick_wide(24, 24'h4_0000), pick_wide(24, 24'h4_0000), pick_wide(16, 16'hFFFF));
			repeat ($urandom_range(10, 40))
				random_item();
			drain();
		end

		$display("run covered %0d input transfers and %0d results over %0d register settings",
			transfers, results_seen, settings);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
`default_nettype wire
